>>> design/lcd_command_decode_and_scanout_assert.svh
// ----------------------------------------------------------------------------
// lcd scanout assertion macros
// concurrent assertion shorthands sampled on clk_i, used by the port checker
// ----------------------------------------------------------------------------
`ifndef LCD_COMMAND_DECODE_AND_SCANOUT_ASSERT_SVH
`define LCD_COMMAND_DECODE_AND_SCANOUT_ASSERT_SVH

// checked outside reset only
`define LCDSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define LCDSC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/lcdsc_pkg.sv
// ----------------------------------------------------------------------------
// lcd scanout package
// shared types, command codes and fixed sizes of the page-mode lcd controller
// ----------------------------------------------------------------------------
package lcdsc_pkg;

  // display ram: 4096 bytes, split into an even and an odd bank
  localparam int RAM_AW     = 12;
  localparam int PAIR_AW    = RAM_AW - 1;
  localparam int PAIR_DEPTH = 1 << PAIR_AW;
  localparam int PROD_W     = 16;

  typedef enum logic [1:0] {
    MODE_CMD   = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  localparam logic [7:0] CMD_COL_LO_MAX = 8'h0F;
  localparam logic [7:0] CMD_COL_HI_MIN = 8'h10;
  localparam logic [7:0] CMD_COL_HI_MAX = 8'h17;
  localparam logic [7:0] CMD_OFFSET_MIN = 8'h40;
  localparam logic [7:0] CMD_OFFSET_MAX = 8'h43;
  localparam logic [7:0] CMD_PAGE_MIN   = 8'hB0;
  localparam logic [7:0] CMD_PAGE_MAX   = 8'hBF;
  localparam logic [7:0] CMD_CONTRAST   = 8'h81;
  localparam logic [7:0] CMD_SLEEP_ON   = 8'hA9;
  localparam logic [7:0] CMD_SLEEP_OFF  = 8'hE1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [23:0] SHADE0_RST = 24'hFFFFFF;
  localparam logic [23:0] SHADE1_RST = 24'hAAAAAA;
  localparam logic [23:0] SHADE2_RST = 24'h555555;
  localparam logic [23:0] SHADE3_RST = 24'h000000;

  typedef logic [3:0][23:0] palette_t;

  typedef struct packed {
    logic       sleep;
    logic [7:0] contrast;
    logic [6:0] column;
    logic [3:0] page;
    logic [4:0] start_page;
  } ctrl_t;

endpackage

>>> design/lcd_command_decode_and_scanout.sv
// ----------------------------------------------------------------------------
// lcd command decode and scanout
// page-mode 2 bit per pixel lcd controller with command decode and pixel reads
// ----------------------------------------------------------------------------
// usage: items enter on the s_axis channel, tuser selects command byte, display
// ram write or pixel read; every transfer in gives one transfer out on m_axis
// carrying the shade, its argb colour and the controller registers after it.
// palette colours are written through the cfg port while the block is idle.
// path: each result passes first the synchronous display ram read and then
// the output register.
// throughput: one item per cycle while m_axis_tready is high, set by the single
// read port of each ram bank; the two bytes of a column sit in the even and the
// odd bank and are read together.
// reset: palette returns to its default shades, pointers, contrast and offset
// clear, power save is off; display ram contents stay undefined until written.
// stall: when m_axis_tready is low the output register and the read stage hold;
// s_axis_tready falls once both are full and rises as soon as one drains.
// ----------------------------------------------------------------------------
module lcd_command_decode_and_scanout import lcdsc_pkg::*; #(
  parameter int SCREEN_WIDTH     = 96,
  parameter int SCREEN_HEIGHT    = 64,
  parameter int COLUMNS_PER_PAGE = 128,
  parameter int PAGES            = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command_byte, ram_address, ram_data, pixel_x, pixel_y, zero fill
  input  logic [47:0] s_axis_tdata,
  // mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // shade_index, pixel_argb, sleep_active, contrast_level, column_pointer,
  // page_pointer, start_page, zero fill
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [23:0] cfg_data_i
);

  logic       accept;
  logic [1:0] mode;
  logic       rd_en;
  logic [PAIR_AW-1:0] rd_pair;
  logic [7:0] rd_even;
  logic [7:0] rd_odd;
  ctrl_t      ctrl;
  ctrl_t      ctrl_nxt;
  palette_t   palette_q;

  assign mode   = s_axis_tuser;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= {SHADE3_RST, SHADE2_RST, SHADE1_RST, SHADE0_RST};
    end else if (cfg_we_i) begin
      palette_q[cfg_addr_i] <= cfg_data_i;
    end
  end

  lcdsc_cmd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(accept && (mode == MODE_CMD)),
    .cmd_byte_i (s_axis_tdata[7:0]),
    .ctrl_o     (ctrl),
    .ctrl_nxt_o (ctrl_nxt)
  );

  lcdsc_dram u_dram (
    .clk_i    (clk_i),
    .wr_en_i  (accept && (mode == MODE_WRITE)),
    .wr_addr_i(s_axis_tdata[19:8]),
    .wr_data_i(s_axis_tdata[27:20]),
    .rd_en_i  (rd_en),
    .rd_pair_i(rd_pair),
    .rd_even_o(rd_even),
    .rd_odd_o (rd_odd)
  );

  lcdsc_scan #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .COLUMNS_PER_PAGE(COLUMNS_PER_PAGE),
    .PAGES           (PAGES)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (mode),
    .pixel_x_i  (s_axis_tdata[34:28]),
    .pixel_y_i  (s_axis_tdata[40:35]),
    .ctrl_nxt_i ((mode == MODE_CMD) ? ctrl_nxt : ctrl),
    .palette_i  (palette_q),
    .rd_en_o    (rd_en),
    .rd_pair_o  (rd_pair),
    .rd_even_i  (rd_even),
    .rd_odd_i   (rd_odd),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

>>> design/lcdsc_cmd_decode.sv
// ----------------------------------------------------------------------------
// lcd scanout command decoder
// holds the controller registers and decodes command and argument bytes
// ----------------------------------------------------------------------------
module lcdsc_cmd_decode import lcdsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  logic [7:0] cmd_byte_i,
  output ctrl_t      ctrl_o,
  output ctrl_t      ctrl_nxt_o
);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_CONTRAST,
    PH_OFFSET
  } phase_e;

  phase_e phase_q, phase_d;
  ctrl_t  ctrl_q, ctrl_d;

  always_comb begin
    phase_d = phase_q;
    ctrl_d  = ctrl_q;
    if (cmd_valid_i) begin
      unique case (phase_q)
        PH_CONTRAST: begin
          ctrl_d.contrast = cmd_byte_i;
          phase_d         = PH_WAIT;
        end
        PH_OFFSET: begin
          ctrl_d.start_page = cmd_byte_i[7:3];
          phase_d           = PH_WAIT;
        end
        default: begin
          phase_d = PH_WAIT;
          if (cmd_byte_i <= CMD_COL_LO_MAX) begin
            ctrl_d.column[3:0] = cmd_byte_i[3:0];
          end else if (cmd_byte_i >= CMD_COL_HI_MIN && cmd_byte_i <= CMD_COL_HI_MAX) begin
            ctrl_d.column[6:4] = cmd_byte_i[2:0];
          end else if (cmd_byte_i >= CMD_OFFSET_MIN && cmd_byte_i <= CMD_OFFSET_MAX) begin
            phase_d = PH_OFFSET;
          end else if (cmd_byte_i >= CMD_PAGE_MIN && cmd_byte_i <= CMD_PAGE_MAX) begin
            ctrl_d.page = cmd_byte_i[3:0];
          end else if (cmd_byte_i == CMD_CONTRAST) begin
            phase_d = PH_CONTRAST;
          end else if (cmd_byte_i == CMD_SLEEP_ON) begin
            ctrl_d.sleep = 1'b1;
          end else if (cmd_byte_i == CMD_SLEEP_OFF) begin
            ctrl_d.sleep = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      ctrl_q  <= '0;
    end else begin
      phase_q <= phase_d;
      ctrl_q  <= ctrl_d;
    end
  end

  assign ctrl_o     = ctrl_q;
  assign ctrl_nxt_o = ctrl_d;

endmodule

>>> design/lcdsc_dram.sv
// ----------------------------------------------------------------------------
// lcd scanout display ram
// two byte-wide banks, even and odd addresses, one write and one read a cycle
// ----------------------------------------------------------------------------
module lcdsc_dram import lcdsc_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [RAM_AW-1:0]  wr_addr_i,
  input  logic [7:0]         wr_data_i,
  input  logic               rd_en_i,
  input  logic [PAIR_AW-1:0] rd_pair_i,
  output logic [7:0]         rd_even_o,
  output logic [7:0]         rd_odd_o
);

  logic [7:0] even_mem [PAIR_DEPTH];
  logic [7:0] odd_mem  [PAIR_DEPTH];
  logic [7:0] rd_even_q;
  logic [7:0] rd_odd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_addr_i[0]) begin
      even_mem[wr_addr_i[RAM_AW-1:1]] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_even_q <= even_mem[rd_pair_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_addr_i[0]) begin
      odd_mem[wr_addr_i[RAM_AW-1:1]] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_odd_q <= odd_mem[rd_pair_i];
    end
  end

  assign rd_even_o = rd_even_q;
  assign rd_odd_o  = rd_odd_q;

endmodule

>>> design/lcdsc_scan.sv
// ----------------------------------------------------------------------------
// lcd scanout pixel pipeline
// address generation, ram read stage, shade lookup and output register
// ----------------------------------------------------------------------------
module lcdsc_scan import lcdsc_pkg::*; #(
  parameter int SCREEN_WIDTH     = 96,
  parameter int SCREEN_HEIGHT    = 64,
  parameter int COLUMNS_PER_PAGE = 128,
  parameter int PAGES            = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [6:0]         pixel_x_i,
  input  logic [5:0]         pixel_y_i,
  input  ctrl_t              ctrl_nxt_i,
  input  palette_t           palette_i,
  output logic               rd_en_o,
  output logic [PAIR_AW-1:0] rd_pair_o,
  input  logic [7:0]         rd_even_i,
  input  logic [7:0]         rd_odd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        out_data_o
);

  localparam logic [5:0]        PAGES_C = 6'(PAGES);
  localparam logic [PROD_W-1:0] CPP_C   = PROD_W'(COLUMNS_PER_PAGE);

  logic              accept;
  logic              s1_adv;
  logic              is_read;
  logic              on_screen;
  logic              hit;
  logic [5:0]        page_sum;
  logic [PROD_W-1:0] pair_full;

  logic       s1_valid_q;
  logic       s1_read_q;
  logic       s1_hit_q;
  logic [2:0] s1_bit_q;
  ctrl_t      s1_ctrl_q;

  logic [1:0] shade;
  logic [31:0] argb;

  logic        out_valid_q;
  logic [63:0] out_data_q;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  assign is_read   = (mode_i == MODE_READ);
  assign on_screen = ({1'b0, pixel_x_i} < 8'(SCREEN_WIDTH)) &&
                     ({2'b00, pixel_y_i} < 8'(SCREEN_HEIGHT));
  assign hit       = is_read && on_screen && !ctrl_nxt_i.sleep;

  always_comb begin
    page_sum = {3'b000, pixel_y_i[5:3]} + {1'b0, ctrl_nxt_i.start_page};
    for (int i = 0; i < 5; i++) begin
      if (page_sum >= PAGES_C) begin
        page_sum = page_sum - PAGES_C;
      end
    end
  end

  assign pair_full = PROD_W'(page_sum) * CPP_C + PROD_W'(pixel_x_i);
  assign rd_pair_o = pair_full[PAIR_AW-1:0];
  assign rd_en_o   = accept && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q <= is_read;
      s1_hit_q  <= hit;
      s1_bit_q  <= pixel_y_i[2:0];
      s1_ctrl_q <= ctrl_nxt_i;
    end
  end

  assign shade = s1_hit_q ? {rd_even_i[s1_bit_q], rd_odd_i[s1_bit_q]} : 2'b00;
  assign argb  = s1_read_q ? {ALPHA_OPAQUE, palette_i[shade]} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_data_q <= {5'b00000, s1_ctrl_q.start_page, s1_ctrl_q.page, s1_ctrl_q.column,
                     s1_ctrl_q.contrast, s1_ctrl_q.sleep, argb, shade};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> design/lcdsc_sva.sv
// ----------------------------------------------------------------------------
// lcd scanout port checker
// temporal checks on the top level ports, bound to the top level
// ----------------------------------------------------------------------------
`include "lcd_command_decode_and_scanout_assert.svh"

module lcdsc_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  `LCDSC_ASSERT_RST(a_no_out_in_reset, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

  `LCDSC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result transfer changed")

  `LCDSC_ASSERT(a_ready_when_drained, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

  `LCDSC_ASSERT(a_sleep_shade, m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[1:0] == 2'b00, "shade nonzero in power save")

  `LCDSC_ASSERT(a_alpha, m_axis_tvalid && (m_axis_tdata[33:2] != 32'h0) |-> m_axis_tdata[33:26] == 8'hFF, "colour not opaque")

endmodule

bind lcd_command_decode_and_scanout lcdsc_sva u_lcdsc_sva (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
